// ----- design/u3gm_pkg.sv -----
// Shared types, constants and tables for the U3 gate matrix generator.
// Used by every module of the block; depends on nothing.
`default_nettype none
package u3gm_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int VALUE_BITS = 16;
   localparam int TURN_BITS  = 32;
   localparam int ROT_BITS   = 34;
   localparam int PROD_BITS  = 2 * ROT_BITS;
   localparam int LANES      = 4;

   localparam int LANE_THETA  = 0;
   localparam int LANE_PHI    = 1;
   localparam int LANE_LAMBDA = 2;
   localparam int LANE_SUM    = 3;

   localparam logic [1:0] CMD_PLAIN    = 2'd0;
   localparam logic [1:0] CMD_D_THETA  = 2'd1;
   localparam logic [1:0] CMD_D_PHI    = 2'd2;
   localparam logic [1:0] CMD_D_LAMBDA = 2'd3;

   localparam logic [1:0] CSR_THETA_EN  = 2'd0;
   localparam logic [1:0] CSR_PHI_EN    = 2'd1;
   localparam logic [1:0] CSR_LAMBDA_EN = 2'd2;

   localparam logic [TURN_BITS-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [TURN_BITS-1:0] EIGHTH_TURN  = 32'h2000_0000;
   localparam logic signed [ROT_BITS-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [ROT_BITS-1:0] ONE_Q30     = 34'sd1073741824;

   // Arctangent of 2^-i in units of 2^-32 turn.
   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   typedef struct packed {
      logic [1:0]            command;
      logic [ANGLE_BITS-1:0] slot_first;
      logic [ANGLE_BITS-1:0] slot_second;
      logic [ANGLE_BITS-1:0] slot_third;
   } u3gm_req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] top_left_real;
      logic signed [VALUE_BITS-1:0] top_left_imag;
      logic signed [VALUE_BITS-1:0] top_right_real;
      logic signed [VALUE_BITS-1:0] top_right_imag;
      logic signed [VALUE_BITS-1:0] bottom_left_real;
      logic signed [VALUE_BITS-1:0] bottom_left_imag;
      logic signed [VALUE_BITS-1:0] bottom_right_real;
      logic signed [VALUE_BITS-1:0] bottom_right_imag;
      logic                         bad_request;
   } u3gm_rsp_type;

   typedef struct packed {
      logic signed [ROT_BITS-1:0] x;
      logic signed [ROT_BITS-1:0] y;
      logic signed [ROT_BITS-1:0] z;
   } u3gm_lane_type;

   typedef struct packed {
      logic                        valid;
      logic                        bad;
      logic [1:0]                  command;
      logic [LANES-1:0]            lane_en;
      logic [LANES-1:0][1:0]       quad;
      u3gm_lane_type [LANES-1:0]   lane;
   } u3gm_cordic_type;

   typedef struct packed {
      logic                      theta;
      logic                      phi;
      logic                      lambda;
   } u3gm_enable_type;

endpackage
`default_nettype wire

// ----- design/u3gm_front.sv -----
// Input stage: assigns packed slots to angles, applies derivative offsets and
// splits each angle into quadrant and residual. Depends on u3gm_pkg.
`default_nettype none
module u3gm_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire u3gm_pkg::u3gm_req_type    req_data,
   input  wire u3gm_pkg::u3gm_enable_type enable,
   output u3gm_pkg::u3gm_cordic_type      front_ff
);
   import u3gm_pkg::*;

   u3gm_cordic_type               front_in;
   logic [TURN_BITS-1:0]          slot   [3];
   logic [TURN_BITS-1:0]          ang    [LANES];
   logic [TURN_BITS-1:0]          resid  [LANES];
   logic [1:0]                    quad   [LANES];
   logic [1:0]                    lambda_idx;
   logic                          bad;

   always_comb begin
      slot[0] = {req_data.slot_first,  {(TURN_BITS-ANGLE_BITS){1'b0}}};
      slot[1] = {req_data.slot_second, {(TURN_BITS-ANGLE_BITS){1'b0}}};
      slot[2] = {req_data.slot_third,  {(TURN_BITS-ANGLE_BITS){1'b0}}};
      lambda_idx = {1'b0, enable.theta} + {1'b0, enable.phi};

      bad = (req_data.command == CMD_D_THETA  && !enable.theta) ||
            (req_data.command == CMD_D_PHI    && !enable.phi) ||
            (req_data.command == CMD_D_LAMBDA && !enable.lambda);

      // A disabled angle counts as zero, which the phi plus lambda sum needs.
      ang[LANE_THETA]  = enable.theta ? slot[0] : '0;
      ang[LANE_PHI]    = enable.phi ? (enable.theta ? slot[1] : slot[0]) : '0;
      ang[LANE_LAMBDA] = enable.lambda ? slot[lambda_idx] : '0;
      if (req_data.command == CMD_D_THETA)  ang[LANE_THETA]  = ang[LANE_THETA] + QUARTER_TURN;
      if (req_data.command == CMD_D_PHI)    ang[LANE_PHI]    = ang[LANE_PHI] + QUARTER_TURN;
      if (req_data.command == CMD_D_LAMBDA) ang[LANE_LAMBDA] = ang[LANE_LAMBDA] + QUARTER_TURN;
      ang[LANE_SUM] = ang[LANE_PHI] + ang[LANE_LAMBDA];

      front_in.valid   = accept && !reset;
      front_in.bad     = bad;
      front_in.command = req_data.command;
      front_in.lane_en = {enable.phi | enable.lambda, enable.lambda, enable.phi, enable.theta};
      for (int k = 0; k < LANES; k++) begin
         quad[k]  = 2'((ang[k] + EIGHTH_TURN) >> (TURN_BITS - 2));
         resid[k] = ang[k] - {quad[k], {(TURN_BITS-2){1'b0}}};
         front_in.quad[k]   = quad[k];
         front_in.lane[k].x = CORDIC_GAIN;
         front_in.lane[k].y = '0;
         front_in.lane[k].z = {{(ROT_BITS-TURN_BITS){resid[k][TURN_BITS-1]}}, resid[k]};
      end
   end

   always_ff @(posedge clock) begin
      front_ff <= front_in;
   end
endmodule
`default_nettype wire

// ----- design/u3gm_cordic_cell.sv -----
// One rotation step of the CORDIC chain, applied to all four angle lanes.
// Depends on u3gm_pkg for the lane types and the arctangent table.
`default_nettype none
module u3gm_cordic_cell #(
   parameter int STAGE = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire u3gm_pkg::u3gm_cordic_type cell_in,
   output u3gm_pkg::u3gm_cordic_type  cell_ff
);
   import u3gm_pkg::*;

   localparam logic signed [ROT_BITS-1:0] ATAN_STEP =
      ROT_BITS'(signed'({1'b0, ATAN_TABLE[STAGE]}));

   u3gm_cordic_type            cell_in_next;
   logic signed [ROT_BITS-1:0] x_cur [LANES];
   logic signed [ROT_BITS-1:0] y_cur [LANES];
   logic signed [ROT_BITS-1:0] x_sh  [LANES];
   logic signed [ROT_BITS-1:0] y_sh  [LANES];

   always_comb begin
      cell_in_next = cell_in;
      cell_in_next.valid = cell_in.valid && !reset;
      for (int k = 0; k < LANES; k++) begin
         x_cur[k] = cell_in.lane[k].x;
         y_cur[k] = cell_in.lane[k].y;
         x_sh[k]  = x_cur[k] >>> STAGE;
         y_sh[k]  = y_cur[k] >>> STAGE;
         if (!cell_in.lane[k].z[ROT_BITS-1]) begin
            cell_in_next.lane[k].x = x_cur[k] - y_sh[k];
            cell_in_next.lane[k].y = y_cur[k] + x_sh[k];
            cell_in_next.lane[k].z = cell_in.lane[k].z - ATAN_STEP;
         end else begin
            cell_in_next.lane[k].x = x_cur[k] + y_sh[k];
            cell_in_next.lane[k].y = y_cur[k] - x_sh[k];
            cell_in_next.lane[k].z = cell_in.lane[k].z + ATAN_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_next;
   end
endmodule
`default_nettype wire

// ----- design/u3gm_combine.sv -----
// Back end: quadrant mapping, matrix element products, rounding and
// saturation to Q1.15. Depends on u3gm_pkg.
`default_nettype none
module u3gm_combine (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire u3gm_pkg::u3gm_cordic_type chain_out,
   output logic                           rsp_strobe,
   output u3gm_pkg::u3gm_rsp_type         rsp_data
);
   import u3gm_pkg::*;

   localparam int SHIFT = 61 - VALUE_BITS;
   localparam logic signed [PROD_BITS-1:0] HALF_LSB = PROD_BITS'(64'sd1 <<< (SHIFT - 1));
   localparam logic signed [PROD_BITS-SHIFT-1:0] MAX_V =
      (PROD_BITS-SHIFT)'((64'sd1 <<< (VALUE_BITS - 1)) - 1);
   localparam logic signed [PROD_BITS-SHIFT-1:0] MIN_V = -MAX_V - 1;

   logic signed [ROT_BITS-1:0]  cos_in [LANES];
   logic signed [ROT_BITS-1:0]  sin_in [LANES];
   logic signed [ROT_BITS-1:0]  cos_ff [LANES];
   logic signed [ROT_BITS-1:0]  sin_ff [LANES];
   logic                        map_valid_ff, map_bad_ff;
   logic [1:0]                  map_cmd_ff;
   logic signed [PROD_BITS-1:0] prod_in [8];
   logic signed [PROD_BITS-1:0] prod_ff [8];
   logic                        prod_valid_ff, prod_bad_ff;
   logic [VALUE_BITS-1:0]       elem   [8];
   u3gm_rsp_type                rsp_in;

   function automatic logic [VALUE_BITS-1:0] round_sat(input logic signed [PROD_BITS-1:0] p);
      logic signed [PROD_BITS-1:0]       r;
      logic signed [PROD_BITS-SHIFT-1:0] v;
      r = p + HALF_LSB;
      v = (PROD_BITS-SHIFT)'(r >>> SHIFT);
      if (v > MAX_V) v = MAX_V;
      if (v < MIN_V) v = MIN_V;
      return v[VALUE_BITS-1:0];
   endfunction

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         case (chain_out.quad[k])
            2'd0: begin
               cos_in[k] = chain_out.lane[k].x;
               sin_in[k] = chain_out.lane[k].y;
            end
            2'd1: begin
               cos_in[k] = -chain_out.lane[k].y;
               sin_in[k] = chain_out.lane[k].x;
            end
            2'd2: begin
               cos_in[k] = -chain_out.lane[k].x;
               sin_in[k] = -chain_out.lane[k].y;
            end
            default: begin
               cos_in[k] = chain_out.lane[k].y;
               sin_in[k] = -chain_out.lane[k].x;
            end
         endcase
         if (!chain_out.lane_en[k]) begin
            cos_in[k] = ONE_Q30;
            sin_in[k] = '0;
         end
      end
   end

   always_comb begin
      prod_in[0] = PROD_BITS'(cos_ff[LANE_THETA]) <<< 30;
      prod_in[1] = '0;
      prod_in[2] = -(cos_ff[LANE_LAMBDA] * sin_ff[LANE_THETA]);
      prod_in[3] = -(sin_ff[LANE_LAMBDA] * sin_ff[LANE_THETA]);
      prod_in[4] = cos_ff[LANE_PHI] * sin_ff[LANE_THETA];
      prod_in[5] = sin_ff[LANE_PHI] * sin_ff[LANE_THETA];
      prod_in[6] = cos_ff[LANE_SUM] * cos_ff[LANE_THETA];
      prod_in[7] = sin_ff[LANE_SUM] * cos_ff[LANE_THETA];
      // The phi derivative clears the first row, the lambda one the first column.
      if (map_cmd_ff == CMD_D_PHI) begin
         prod_in[0] = '0;
         prod_in[2] = '0;
         prod_in[3] = '0;
      end
      if (map_cmd_ff == CMD_D_LAMBDA) begin
         prod_in[0] = '0;
         prod_in[4] = '0;
         prod_in[5] = '0;
      end
      if (map_bad_ff) begin
         for (int e = 0; e < 8; e++) prod_in[e] = '0;
      end
   end

   always_comb begin
      for (int e = 0; e < 8; e++) elem[e] = round_sat(prod_ff[e]);
      rsp_in.top_left_real     = elem[0];
      rsp_in.top_left_imag     = elem[1];
      rsp_in.top_right_real    = elem[2];
      rsp_in.top_right_imag    = elem[3];
      rsp_in.bottom_left_real  = elem[4];
      rsp_in.bottom_left_imag  = elem[5];
      rsp_in.bottom_right_real = elem[6];
      rsp_in.bottom_right_imag = elem[7];
      rsp_in.bad_request       = prod_bad_ff;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         cos_ff[k] <= cos_in[k];
         sin_ff[k] <= sin_in[k];
      end
      map_bad_ff  <= chain_out.bad;
      map_cmd_ff  <= chain_out.command;
      for (int e = 0; e < 8; e++) prod_ff[e] <= prod_in[e];
      prod_bad_ff <= map_bad_ff;
      rsp_data    <= rsp_in;
      if (reset) begin
         map_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_strobe    <= 1'b0;
      end else begin
         map_valid_ff  <= chain_out.valid;
         prod_valid_ff <= map_valid_ff;
         rsp_strobe    <= prod_valid_ff;
      end
   end
endmodule
`default_nettype wire

// ----- design/u3_gate_matrix_generator_top.sv -----
// Top level of the U3 gate matrix generator: enable registers, input stage,
// CORDIC cell chain and back end. Depends on u3gm_pkg and its three submodules.
//
//   channel   ports                                 handshake
//   request   start, busy, req_data                 start && !busy
//   response  rsp_strobe, rsp_data                  one-cycle strobe
//   config    csr_write_enable, csr_index, csr_write_data write when enable high
//
// One item per cycle is taken; busy is always low. An item's result passes
// through one input stage, one cell per rotation step, then the mapping,
// product and rounding registers.
// Synchronous reset clears the valid bits of the pipeline and sets all three
// angle enables. The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module u3_gate_matrix_generator_top #(
   parameter int ROTATION_STAGES = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire u3gm_pkg::u3gm_req_type req_data,
   output logic                        rsp_strobe,
   output u3gm_pkg::u3gm_rsp_type      rsp_data,
   input  wire logic                   csr_write_enable,
   input  wire logic [1:0]             csr_index,
   input  wire logic                   csr_write_data
);
   import u3gm_pkg::*;

   u3gm_enable_type enable_ff;
   u3gm_cordic_type chain [ROTATION_STAGES+1];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '{theta: 1'b1, phi: 1'b1, lambda: 1'b1};
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_THETA_EN:  enable_ff.theta  <= csr_write_data;
            CSR_PHI_EN:    enable_ff.phi    <= csr_write_data;
            CSR_LAMBDA_EN: enable_ff.lambda <= csr_write_data;
            default: ;
         endcase
      end
   end

   u3gm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (start && !busy),
      .req_data (req_data),
      .enable   (enable_ff),
      .front_ff (chain[0])
   );

   for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cell
      u3gm_cordic_cell #(.STAGE(g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_in (chain[g]),
         .cell_ff (chain[g+1])
      );
   end

   u3gm_combine u_combine (
      .clock      (clock),
      .reset      (reset),
      .chain_out  (chain[ROTATION_STAGES]),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );
endmodule
`default_nettype wire

// ----- design/u3gm_checker.sv -----
// Port-level checker for the U3 gate matrix generator, bound to the top level.
// Depends on u3gm_pkg.
`default_nettype none
module u3gm_port_assertions #(
   parameter int ROTATION_STAGES = 16
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire u3gm_pkg::u3gm_req_type req_data,
   input wire logic                   rsp_strobe,
   input wire u3gm_pkg::u3gm_rsp_type rsp_data
);
   import u3gm_pkg::*;

   localparam int LATENCY = ROTATION_STAGES + 4;

   // Every accepted item is followed by a result strobe.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted item produced no result");

   // No result appears without an earlier accepted item.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without an accepted item");

   // A flagged request gives an all-zero matrix.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.bad_request) |->
         (rsp_data.top_right_real == '0 && rsp_data.top_right_imag == '0 &&
          rsp_data.bottom_left_real == '0 && rsp_data.bottom_left_imag == '0 &&
          rsp_data.bottom_right_real == '0 && rsp_data.bottom_right_imag == '0 &&
          rsp_data.top_left_real == '0))
      else $error("flagged request with nonzero matrix");

   // Only a derivative command can be flagged.
   a_bad_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.bad_request) |->
         $past(req_data.command, LATENCY) != CMD_PLAIN)
      else $error("plain matrix request flagged");

   // The top left element is always real.
   a_tl_real: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.top_left_imag == '0)
      else $error("top left imaginary part nonzero");
endmodule

bind u3_gate_matrix_generator_top u3gm_port_assertions #(.ROTATION_STAGES(ROTATION_STAGES))
   u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
`default_nettype wire

// ----- dv/u3gm_checker.sv -----
// Checker for the U3 gate matrix generator: watches request, response and
// register ports, predicts each matrix and compares. Depends on u3gm_pkg.
`timescale 1ns / 1ps
module u3gm_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  u3gm_pkg::u3gm_req_type req_data,
   input  logic                   rsp_strobe,
   input  u3gm_pkg::u3gm_rsp_type rsp_data,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  logic                   csr_write_data,
   output int                     fail_count,
   output int                     pending
);
   import u3gm_pkg::*;

   localparam int STAGES = 16;
   localparam longint UNITY = 64'sd1 << 30;

   u3gm_rsp_type matrix_queue[$];
   bit           theta_on, phi_on, lambda_on;
   int           mismatches;

   assign pending = matrix_queue.size();
   assign fail_count = mismatches;

   // Cosine and sine in Q2.30 of a 32-bit binary angle.
   function automatic void rotate_angle(input bit en, input logic [31:0] ang,
                                        output longint c, output longint s);
      logic [31:0] q, r;
      longint x, y, z, nx;
      if (!en) begin
         c = UNITY;
         s = 0;
         return;
      end
      q = (ang + EIGHTH_TURN) >> 30;
      r = ang - (q << 30);
      z = longint'($signed(r));
      x = 652032874;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(ATAN_TABLE[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(ATAN_TABLE[i]);
         end
         x = nx;
      end
      case (q[1:0])
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   // Q4.60 product rounded half up and saturated to Q1.15.
   function automatic logic [VALUE_BITS-1:0] round_q15(input longint p);
      longint v;
      v = (p + (64'sd1 << 44)) >>> 45;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[VALUE_BITS-1:0];
   endfunction

   function automatic u3gm_rsp_type gate_matrix(input u3gm_req_type item);
      logic [31:0] slots[3];
      logic [31:0] at, ap, al;
      longint ct, st, cp, sp, cl, sl, cs, ss;
      longint m[8];
      int n;
      bit bad;
      u3gm_rsp_type res;
      slots[0] = {item.slot_first, 16'h0};
      slots[1] = {item.slot_second, 16'h0};
      slots[2] = {item.slot_third, 16'h0};
      n = 0;
      at = 0; ap = 0; al = 0;
      if (theta_on) begin
         at = slots[n];
         n++;
      end
      if (phi_on) begin
         ap = slots[n];
         n++;
      end
      if (lambda_on) begin
         al = slots[n];
         n++;
      end
      bad = (item.command == CMD_D_THETA && !theta_on) ||
            (item.command == CMD_D_PHI && !phi_on) ||
            (item.command == CMD_D_LAMBDA && !lambda_on);
      for (int i = 0; i < 8; i++) m[i] = 0;
      if (!bad) begin
         if (item.command == CMD_D_THETA) at += QUARTER_TURN;
         if (item.command == CMD_D_PHI) ap += QUARTER_TURN;
         if (item.command == CMD_D_LAMBDA) al += QUARTER_TURN;
         rotate_angle(theta_on, at, ct, st);
         rotate_angle(phi_on, ap, cp, sp);
         rotate_angle(lambda_on, al, cl, sl);
         rotate_angle(phi_on || lambda_on, ap + al, cs, ss);
         m[0] = ct * UNITY;
         m[2] = -(cl * st);
         m[3] = -(sl * st);
         m[4] = cp * st;
         m[5] = sp * st;
         m[6] = cs * ct;
         m[7] = ss * ct;
         if (item.command == CMD_D_PHI) begin
            m[0] = 0; m[2] = 0; m[3] = 0;
         end
         if (item.command == CMD_D_LAMBDA) begin
            m[0] = 0; m[4] = 0; m[5] = 0;
         end
      end
      res.top_left_real     = round_q15(m[0]);
      res.top_left_imag     = round_q15(m[1]);
      res.top_right_real    = round_q15(m[2]);
      res.top_right_imag    = round_q15(m[3]);
      res.bottom_left_real  = round_q15(m[4]);
      res.bottom_left_imag  = round_q15(m[5]);
      res.bottom_right_real = round_q15(m[6]);
      res.bottom_right_imag = round_q15(m[7]);
      res.bad_request       = bad;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0d got %0d", name,
                     $signed(want), $signed(got));
      end
   endtask

   always @(posedge clock) begin
      u3gm_rsp_type want;
      if (reset) begin
         theta_on <= 1;
         phi_on <= 1;
         lambda_on <= 1;
         matrix_queue.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_THETA_EN:  theta_on <= csr_write_data;
               CSR_PHI_EN:    phi_on <= csr_write_data;
               CSR_LAMBDA_EN: lambda_on <= csr_write_data;
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (matrix_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("result with no item outstanding");
            end else begin
               want = matrix_queue.pop_front();
               check_field("top_left_real", want.top_left_real, rsp_data.top_left_real);
               check_field("top_left_imag", want.top_left_imag, rsp_data.top_left_imag);
               check_field("top_right_real", want.top_right_real,
                           rsp_data.top_right_real);
               check_field("top_right_imag", want.top_right_imag,
                           rsp_data.top_right_imag);
               check_field("bottom_left_real", want.bottom_left_real,
                           rsp_data.bottom_left_real);
               check_field("bottom_left_imag", want.bottom_left_imag,
                           rsp_data.bottom_left_imag);
               check_field("bottom_right_real", want.bottom_right_real,
                           rsp_data.bottom_right_real);
               check_field("bottom_right_imag", want.bottom_right_imag,
                           rsp_data.bottom_right_imag);
               check_field("bad_request", 16'(want.bad_request),
                           16'(rsp_data.bad_request));
            end
         end
         if (start && !busy) matrix_queue = {matrix_queue, gate_matrix(req_data)};
      end
   end
endmodule

// ----- dv/tb_u3_gate_matrix_generator_top.sv -----
// Testbench top for the U3 gate matrix generator: clock, reset, stimulus over several
// enable settings and the verdict. Depends on u3gm_pkg, u3gm_checker and the DUT top.
`timescale 1ns / 1ps
module tb_u3_gate_matrix_generator_top;
   import u3gm_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int PIPE_DEPTH = 20;
   localparam int CYCLE_LIMIT = 400000;

   logic         clock = 0;
   logic         reset = 1;
   logic         start = 0;
   logic         busy;
   u3gm_req_type req_data = '0;
   logic         rsp_strobe;
   u3gm_rsp_type rsp_data;
   logic         csr_write_enable = 0;
   logic [1:0]   csr_index = '0;
   logic         csr_write_data = 0;
   int           fail_count, pending, cycles, items_sent;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   u3_gate_matrix_generator_top u_dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data,
      .csr_write_enable, .csr_index, .csr_write_data
   );

   u3gm_checker u_checker (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data,
      .csr_write_enable, .csr_index, .csr_write_data, .fail_count, .pending
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Start is left high when the next item follows without a gap.
   task automatic send_item(input logic [1:0] cmd, input logic [15:0] a,
                            input logic [15:0] b, input logic [15:0] c);
      int gap;
      start <= 1;
      req_data <= '{command: cmd, slot_first: a, slot_second: b, slot_third: c};
      do @(posedge clock); while (busy);
      items_sent++;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain;
      start <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_enables(input logic [2:0] en);
      logic [1:0] idx[4];
      idx = '{CSR_THETA_EN, CSR_PHI_EN, CSR_LAMBDA_EN, CSR_UNUSED};
      drain();
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1;
         csr_index <= idx[i];
         csr_write_data <= (i < 3) ? en[2 - i] : logic'($urandom_range(0, 1));
         @(posedge clock);
      end
      csr_write_enable <= 0;
   endtask

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(0, 5))
         0: return 16'hffff;
         1: return 16'h0000;
         2: return 16'(($urandom_range(0, 7) << 13) + $urandom_range(0, 6) - 3);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] dir_angles[10];
      logic [2:0]  settings[8];
      dir_angles = '{16'h0000, 16'hffff, 16'h8000, 16'h4000, 16'h2000,
                     16'h1fff, 16'h6000, 16'hc000, 16'h0001, 16'h5555};
      settings = '{3'b000, 3'b100, 3'b010, 3'b001, 3'b110, 3'b101, 3'b011, 3'b111};
      cycles = 0;
      items_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: angle extremes and quadrant edges, then every command.
      for (int i = 0; i < 10; i++)
         send_item(CMD_PLAIN, dir_angles[i], dir_angles[9 - i], dir_angles[(i + 3) % 10]);
      send_item(CMD_D_THETA, 16'h0000, 16'hffff, 16'h8000);
      send_item(CMD_D_PHI, 16'hffff, 16'h4000, 16'h2000);
      send_item(CMD_D_LAMBDA, 16'h8000, 16'h0000, 16'hffff);
      send_item(CMD_D_THETA, 16'hc000, 16'h1fff, 16'h6000);
      write_enables(3'b000);
      send_item(CMD_PLAIN, 16'h1234, 16'hffff, 16'h0000);
      send_item(CMD_D_THETA, 16'hffff, 16'hffff, 16'hffff);
      send_item(CMD_D_PHI, 16'h0000, 16'h0000, 16'h0000);
      send_item(CMD_D_LAMBDA, 16'h8000, 16'h4000, 16'h2000);

      for (int p = 0; p < 8; p++) begin
         write_enables(settings[p]);
         repeat (80)
            send_item(2'($urandom_range(0, 3)), pick_angle(), pick_angle(), pick_angle());
      end

      drain();
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      $display("Sent %0d items across eight enable settings, plain and derivative commands.",
               items_sent);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d field mismatches or stray results.", fail_count);
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
design/u3gm_pkg.sv
design/u3gm_front.sv
design/u3gm_cordic_cell.sv
design/u3gm_combine.sv
design/u3_gate_matrix_generator_top.sv
design/u3gm_checker.sv
dv/u3gm_checker.sv
dv/tb_u3_gate_matrix_generator_top.sv
